FILE: hw/rtl/rc4_pkg.sv
package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int PERM_DEPTH        = 256;
    localparam int PERM_ADDR_W       = $clog2(PERM_DEPTH);
    localparam int KEY_REG_W         = 64;
    localparam int KEY_BYTES_MAX     = 16;
    localparam int KEY_BYTES_DEFAULT = 16;
    localparam int CFG_IDX_W         = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(1);

    // one access cycle to the permutation memory
    typedef struct packed {
        logic                   we;
        logic [PERM_ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0]      wdata;
        logic                   re;
        logic [PERM_ADDR_W-1:0] raddr;
    } perm_req_t;

endpackage

FILE: hw/rtl/rc4_stream_if.sv
interface rc4_in_if;
    logic                      valid;
    logic                      ready;
    logic [rc4_pkg::BYTE_W-1:0] data_byte;
    logic                      end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface rc4_out_if;
    logic                      valid;
    logic                      ready;
    logic [rc4_pkg::BYTE_W-1:0] out_byte;
    logic                      out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: hw/rtl/rc4_perm_ram.sv
module rc4_perm_ram (
    input  logic                             clk,
    input  rc4_pkg::perm_req_t               req,
    output logic [rc4_pkg::BYTE_W-1:0]       rd_data
);

    logic [rc4_pkg::BYTE_W-1:0] mem [rc4_pkg::PERM_DEPTH];

    // read-first: a read and a write to one entry in the same cycle return the old value
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

FILE: hw/rtl/rc4_stream_cipher_core.sv
// Channel    Dir   Handshake      Payload
// data_in    in    valid/ready    data_byte[7:0], end_of_message
// data_out   out   valid/ready    out_byte[7:0], out_last
// cfg        in    cfg_we         cfg_index[1:0], cfg_data[63:0] (0 key_low, 1 key_high)
//
// A byte inside a message runs through four steps: accept/read S[i], read S[j], write S[i] and
// read S[t], write S[j] and load the output register. The single-port-write memory sets this.
// The first byte of a message adds the fill of all 256 entries, the schedule over every entry
// (read S[n], read S[j], write S[n], write S[j]) and one state to start the step.
// Reset (rst_n low, async) clears control, the key and the indexes; the memory is not cleared,
// the first schedule rewrites it. The next byte is taken while a result waits; the last step
// holds until the output register is free.
module rc4_stream_cipher_core #(
    parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rc4_in_if.sink                            data_in,
    rc4_out_if.source                         data_out,
    input  logic                              cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rc4_pkg::KEY_REG_W-1:0]     cfg_data
);

    localparam int AW     = rc4_pkg::PERM_ADDR_W;
    localparam int BW     = rc4_pkg::BYTE_W;
    localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int KSEL_W = $clog2(rc4_pkg::KEY_BYTES_MAX);
    localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);
    localparam logic [AW-1:0]     LAST_ENTRY = AW'(rc4_pkg::PERM_DEPTH - 1);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_FILL     = 10'b00_0000_0010,
        ST_KS_RD_N  = 10'b00_0000_0100,
        ST_KS_RD_J  = 10'b00_0000_1000,
        ST_KS_WR_N  = 10'b00_0001_0000,
        ST_KS_WR_J  = 10'b00_0010_0000,
        ST_GEN_RD_I = 10'b00_0100_0000,
        ST_GEN_RD_J = 10'b00_1000_0000,
        ST_GEN_WR_I = 10'b01_0000_0000,
        ST_GEN_OUT  = 10'b10_0000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                n_reg, n_next;       // schedule entry
    logic [AW-1:0]                i_reg, i_next;       // step index
    logic [AW-1:0]                j_reg, j_next;       // swap index (shared by schedule)
    logic [KIDX_W-1:0]            kidx_reg, kidx_next;
    logic [BW-1:0]                sx_reg, sx_next;     // S[n] or S[i]
    logic [BW-1:0]                sy_reg, sy_next;     // S[j]
    logic [AW-1:0]                t_reg, t_next;
    logic [BW-1:0]                data_reg, data_next;
    logic                         last_reg, last_next;
    logic                         need_sched_reg, need_sched_next;
    logic                         out_valid_reg, out_valid_next;
    logic [BW-1:0]                out_byte_reg, out_byte_next;
    logic                         out_last_reg, out_last_next;
    logic [rc4_pkg::KEY_REG_W-1:0] key_low_reg, key_high_reg;

    rc4_pkg::perm_req_t           ram_req;
    logic [BW-1:0]                rd_data;

    logic                         in_acc;
    logic                         out_free;
    logic                         out_load;
    logic [2*rc4_pkg::KEY_REG_W-1:0] key_all;
    logic [KSEL_W-1:0]            key_sel;
    logic [BW-1:0]                key_byte;
    logic [BW-1:0]                ks;

    rc4_perm_ram u_perm (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign data_in.ready  = (state_reg == ST_IDLE);
    assign in_acc         = data_in.valid && data_in.ready;
    assign out_free       = !out_valid_reg || data_out.ready;

    assign data_out.valid    = out_valid_reg;
    assign data_out.out_byte = out_byte_reg;
    assign data_out.out_last = out_last_reg;

    assign key_all  = {key_high_reg, key_low_reg};
    assign key_sel  = KSEL_W'(kidx_reg);
    assign key_byte = key_all[{key_sel, 3'b000} +: BW];

    // keystream byte after the swap: entries i and j already hold their new values
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            ks = sx_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks = sy_reg;
        end
        else
        begin
            ks = rd_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        kidx_next       = kidx_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        t_next          = t_reg;
        data_next       = data_reg;
        last_next       = last_reg;
        need_sched_next = need_sched_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        ram_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    data_next = data_in.data_byte;
                    last_next = data_in.end_of_message;
                    if (need_sched_reg)
                    begin
                        n_next     = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        i_next        = i_reg + AW'(1);
                        ram_req.re    = 1'b1;
                        ram_req.raddr = i_reg + AW'(1);
                        state_next    = ST_GEN_RD_J;
                    end
                end
            end
            ST_FILL:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = n_reg;
                ram_req.wdata = BW'(n_reg);
                n_next        = n_reg + AW'(1);
                if (n_reg == LAST_ENTRY)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = ST_KS_RD_N;
                end
            end
            ST_KS_RD_N:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = n_reg;
                state_next    = ST_KS_RD_J;
            end
            ST_KS_RD_J:
            begin
                sx_next       = rd_data;
                j_next        = j_reg + AW'(rd_data) + AW'(key_byte);
                ram_req.re    = 1'b1;
                ram_req.raddr = j_reg + AW'(rd_data) + AW'(key_byte);
                state_next    = ST_KS_WR_N;
            end
            ST_KS_WR_N:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = n_reg;
                ram_req.wdata = rd_data;
                state_next    = ST_KS_WR_J;
            end
            ST_KS_WR_J:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = sx_reg;
                n_next        = n_reg + AW'(1);
                kidx_next     = (kidx_reg == KIDX_LAST) ? '0 : kidx_reg + KIDX_W'(1);
                if (n_reg == LAST_ENTRY)
                begin
                    i_next          = '0;
                    j_next          = '0;
                    need_sched_next = 1'b0;
                    state_next      = ST_GEN_RD_I;
                end
                else
                begin
                    state_next = ST_KS_RD_N;
                end
            end
            ST_GEN_RD_I:
            begin
                i_next        = i_reg + AW'(1);
                ram_req.re    = 1'b1;
                ram_req.raddr = i_reg + AW'(1);
                state_next    = ST_GEN_RD_J;
            end
            ST_GEN_RD_J:
            begin
                sx_next       = rd_data;
                j_next        = j_reg + AW'(rd_data);
                ram_req.re    = 1'b1;
                ram_req.raddr = j_reg + AW'(rd_data);
                state_next    = ST_GEN_WR_I;
            end
            ST_GEN_WR_I:
            begin
                sy_next       = rd_data;
                t_next        = AW'(sx_reg) + AW'(rd_data);
                ram_req.re    = 1'b1;
                ram_req.raddr = AW'(sx_reg) + AW'(rd_data);
                ram_req.we    = 1'b1;
                ram_req.waddr = i_reg;
                ram_req.wdata = rd_data;
                state_next    = ST_GEN_OUT;
            end
            ST_GEN_OUT:
            begin
                // hold here, with rd_data stable, until the output register frees up
                if (out_free)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = j_reg;
                    ram_req.wdata = sx_reg;
                    out_load      = 1'b1;
                    out_byte_next = data_reg ^ ks;
                    out_last_next = last_reg;
                    if (last_reg)
                    begin
                        need_sched_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (data_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            kidx_reg       <= '0;
            need_sched_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            kidx_reg       <= kidx_next;
            need_sched_reg <= need_sched_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == rc4_pkg::CFG_KEY_LOW)
                begin
                    key_low_reg <= cfg_data;
                end
                else if (cfg_index == rc4_pkg::CFG_KEY_HIGH)
                begin
                    key_high_reg <= cfg_data;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // the end of the schedule hands over zeroed indexes to the first step
    a_sched_handover: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KS_WR_J && n_reg == LAST_ENTRY)
        |=> (i_reg == '0 && j_reg == '0 && state_reg == ST_GEN_RD_I && !need_sched_reg))
        else $error("schedule did not hand over cleanly");

    // a keystream step never starts while a schedule is still owed
    a_no_step_unscheduled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GEN_RD_J) |-> !need_sched_reg)
        else $error("keystream step without key schedule");

    // a result is never loaded over one that is still waiting
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || data_out.ready))
        else $error("output register overwritten");

    // an accepted item always leaves idle and closes the input
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != ST_IDLE && !data_in.ready))
        else $error("accepted item did not start work");

endmodule
